### src/dfp_pkg.sv
// Shared types, character codes and limits of the detection frame parser.
package dfp_pkg;

    // Longest frame, '$' excluded, that the parser collects
    localparam int BUFFER_SIZE = 32;
    localparam int CNT_W       = $clog2(BUFFER_SIZE);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 10;
    localparam int CLASS_W = 4;
    localparam int HCLS_W  = 3;
    localparam int SCORE_W = 7;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_START   = 8'h24;
    localparam logic [BYTE_W-1:0] CH_END     = 8'h23;
    localparam logic [BYTE_W-1:0] CH_TAG     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7E;

    // Field limits
    localparam logic [ACC_W-1:0] ACC_MAX       = 10'd1023;
    localparam logic [ACC_W-1:0] ACC_SAT_LIMIT = 10'd102;
    localparam logic [ACC_W-1:0] CLASS_MAX     = 10'd4;
    localparam logic [ACC_W-1:0] SCORE_MAX     = 10'd100;
    localparam logic [ACC_W-1:0] X_MAX         = 10'd319;
    localparam logic [ACC_W-1:0] Y_MAX         = 10'd239;

    // Result status codes
    typedef enum logic [1:0] {
        ST_IGNORED   = 2'd0,
        ST_COLLECT   = 2'd1,
        ST_COMPLETE  = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    // Grammar position inside a frame
    typedef enum logic [5:0] {
        PH_TAG   = 6'b000001,
        PH_SEP   = 6'b000010,
        PH_CLASS = 6'b000100,
        PH_SCORE = 6'b001000,
        PH_X     = 6'b010000,
        PH_Y     = 6'b100000
    } phase_t;

    // One received byte between the input register and the parser
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_item_t;

    // One parse result
    typedef struct packed {
        status_t                    status;
        logic signed [CLASS_W-1:0]  obj_class;
        logic [SCORE_W-1:0]         score;
        logic [X_W-1:0]             obj_col;
        logic [Y_W-1:0]             obj_row;
    } result_t;

endpackage

### src/dfp_in_stage.sv
// Input register of the detection frame parser.
module dfp_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dfp_pkg::BYTE_W-1:0] s_rx_byte,
    output dfp_pkg::byte_item_t        item,
    input  logic                       item_ready
);
    import dfp_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // Take a new item when empty or when the held one moves on
    assign s_ready = !valid_reg || item_ready;

    // Hold the received byte until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

### src/dfp_parser.sv
// Frame parse state, per-byte update logic and result register.
module dfp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfp_pkg::byte_item_t item,
    output logic                item_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output dfp_pkg::result_t    result
);
    import dfp_pkg::*;

    // Parse state
    logic              collecting_reg, collecting_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    phase_t            phase_reg, phase_next;
    logic              bad_reg, bad_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HCLS_W-1:0] hcls_reg, hcls_next;
    logic [SCORE_W-1:0] hscore_reg, hscore_next;
    logic [X_W-1:0]    hx_reg, hx_next;

    // Result register
    logic              out_valid_reg;
    result_t           out_reg, out_next;

    logic              advance;

    // Range check of the current field for a given phase
    function automatic logic field_ok(phase_t ph, logic seen, logic neg,
                                      logic [ACC_W-1:0] acc);
        logic in_range;
        in_range = 1'b0;
        case (ph)
            PH_CLASS: in_range = neg ? (acc <= 10'd1) : (acc <= CLASS_MAX);
            PH_SCORE: in_range = neg ? (acc == '0) : (acc <= SCORE_MAX);
            PH_X:     in_range = neg ? (acc == '0) : (acc <= X_MAX);
            PH_Y:     in_range = neg ? (acc == '0) : (acc <= Y_MAX);
            default:  in_range = 1'b0;
        endcase
        return seen && in_range;
    endfunction

    assign item_ready = !out_valid_reg || m_ready;
    assign advance    = item.valid && item_ready;

    // Work out the next parse state and the result of one byte
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic [ACC_W+2:0]  acc_wide;
        logic              y_ok;
        logic signed [CLASS_W-1:0] cls;

        b        = item.data;
        acc_wide = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                 + {{(ACC_W-1){1'b0}}, 4'(b - CH_ZERO)};
        y_ok     = field_ok(PH_Y, seen_reg, neg_reg, acc_reg);
        cls      = $signed({1'b0, hcls_reg}) - 4'sd1;

        collecting_next = collecting_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        bad_next        = bad_reg;
        neg_next        = neg_reg;
        seen_next       = seen_reg;
        acc_next        = acc_reg;
        hcls_next       = hcls_reg;
        hscore_next     = hscore_reg;
        hx_next         = hx_reg;

        out_next          = '0;
        out_next.status   = ST_IGNORED;

        if (b == CH_START) begin
            // Open or restart a frame
            collecting_next = 1'b1;
            count_next      = '0;
            phase_next      = PH_TAG;
            bad_next        = 1'b0;
            neg_next        = 1'b0;
            seen_next       = 1'b0;
            acc_next        = '0;
            out_next.status = ST_COLLECT;
        end else if (!collecting_reg) begin
            out_next.status = ST_IGNORED;
        end else if (b == CH_END) begin
            // Close the frame and report it
            out_next.status = ST_BAD;
            if (!bad_reg && phase_reg == PH_Y && y_ok) begin
                if (!(hcls_reg == '0 &&
                      (hscore_reg != '0 || hx_reg != '0 || acc_reg != '0))) begin
                    out_next.status    = ST_COMPLETE;
                    out_next.obj_class = cls;
                    out_next.score     = hscore_reg;
                    out_next.obj_col   = hx_reg;
                    out_next.obj_row   = acc_reg[Y_W-1:0];
                end
            end
            collecting_next = 1'b0;
            count_next      = '0;
            phase_next      = PH_TAG;
            bad_next        = 1'b0;
            neg_next        = 1'b0;
            seen_next       = 1'b0;
            acc_next        = '0;
        end else if (b < PRINT_LOW || b > PRINT_HIGH ||
                     count_reg >= CNT_W'(BUFFER_SIZE - 1)) begin
            // Abort on a non-printable byte or an overlong frame
            collecting_next = 1'b0;
            count_next      = '0;
            phase_next      = PH_TAG;
            bad_next        = 1'b0;
            neg_next        = 1'b0;
            seen_next       = 1'b0;
            acc_next        = '0;
            out_next.status = ST_BAD;
        end else begin
            // Advance the grammar by one printable byte
            count_next      = count_reg + CNT_W'(1);
            out_next.status = ST_COLLECT;
            if (!bad_reg) begin
                case (phase_reg)
                    PH_TAG: begin
                        if (b == CH_TAG) phase_next = PH_SEP;
                        else bad_next = 1'b1;
                    end
                    PH_SEP: begin
                        if (b == CH_COMMA) phase_next = PH_CLASS;
                        else bad_next = 1'b1;
                    end
                    PH_CLASS, PH_SCORE, PH_X, PH_Y: begin
                        if (b == CH_COMMA && phase_reg != PH_Y) begin
                            if (!field_ok(phase_reg, seen_reg, neg_reg, acc_reg)) begin
                                bad_next = 1'b1;
                            end else begin
                                case (phase_reg)
                                    PH_CLASS: begin
                                        hcls_next  = neg_reg ? (acc_reg[0] ? 3'd0 : 3'd1)
                                                   : acc_reg[HCLS_W-1:0] + 3'd1;
                                        phase_next = PH_SCORE;
                                    end
                                    PH_SCORE: begin
                                        hscore_next = acc_reg[SCORE_W-1:0];
                                        phase_next  = PH_X;
                                    end
                                    default: begin
                                        hx_next    = acc_reg[X_W-1:0];
                                        phase_next = PH_Y;
                                    end
                                endcase
                                neg_next  = 1'b0;
                                seen_next = 1'b0;
                                acc_next  = '0;
                            end
                        end else if (b == CH_MINUS && !seen_reg && !neg_reg) begin
                            neg_next = 1'b1;
                        end else if (b >= CH_ZERO && b <= CH_NINE) begin
                            if (acc_reg > ACC_SAT_LIMIT || acc_wide > {3'b000, ACC_MAX}) begin
                                acc_next = ACC_MAX;
                            end else begin
                                acc_next = acc_wide[ACC_W-1:0];
                            end
                            seen_next = 1'b1;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end
                    default: bad_next = 1'b1;
                endcase
            end
        end
    end

    // Update parse state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            phase_reg      <= PH_TAG;
            bad_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            seen_reg       <= 1'b0;
            acc_reg        <= '0;
            hcls_reg       <= '0;
            hscore_reg     <= '0;
            hx_reg         <= '0;
        end else if (advance) begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            bad_reg        <= bad_next;
            neg_reg        <= neg_next;
            seen_reg       <= seen_next;
            acc_reg        <= acc_next;
            hcls_reg       <= hcls_next;
            hscore_reg     <= hscore_next;
            hx_reg         <= hx_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_ready) begin
            out_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule

### src/detection_frame_parser_core.sv
// Top level of the detection frame parser.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    s_rx_byte
//   m_        out         m_valid/m_ready    m_status, m_obj_class, m_score,
//                                            m_obj_col, m_obj_row
//
// An accepted byte is held in the input register; the parser step then
// loads the result register from it, and one item per cycle is sustained
// while m_ready does not stall the result.
// The per-byte grammar step and multiply-by-ten accumulate sit between them.
// aresetn is synchronous and clears the parse state and both valid flags.
// A stalled m_ready holds the result; the input register keeps taking items
// until both registers are full.
module detection_frame_parser_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dfp_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [dfp_pkg::CLASS_W-1:0]  m_obj_class,
    output logic [dfp_pkg::SCORE_W-1:0]         m_score,
    output logic [dfp_pkg::X_W-1:0]             m_obj_col,
    output logic [dfp_pkg::Y_W-1:0]             m_obj_row
);
    import dfp_pkg::*;

    byte_item_t item;
    logic       item_ready;
    result_t    result;

    dfp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .item       (item),
        .item_ready (item_ready)
    );

    dfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .item_ready (item_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    // Spread the result onto its ports
    assign m_status    = result.status;
    assign m_obj_class = result.obj_class;
    assign m_score     = result.score;
    assign m_obj_col   = result.obj_col;
    assign m_obj_row   = result.obj_row;

endmodule

### src/dfp_checker.sv
// Port-level assertions of the detection frame parser and their bind.
module dfp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [1:0]                          m_status,
    input logic signed [dfp_pkg::CLASS_W-1:0]  m_obj_class,
    input logic [dfp_pkg::SCORE_W-1:0]         m_score,
    input logic [dfp_pkg::X_W-1:0]             m_obj_col,
    input logic [dfp_pkg::Y_W-1:0]             m_obj_row
);
    import dfp_pkg::*;

    // No result and an open input right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("result valid or input blocked after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_obj_class)
            && $stable(m_score) && $stable(m_obj_col) && $stable(m_obj_row))
        else $error("stalled result changed");

    // Zero payload unless the frame is complete
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_COMPLETE |->
            m_obj_class == '0 && m_score == '0 && m_obj_col == '0 && m_obj_row == '0)
        else $error("payload nonzero without complete frame");

    // Complete frames stay inside the field limits
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_COMPLETE |->
            m_obj_class >= -4'sd1 && m_obj_class <= 4'sd4 && m_score <= 7'd100
            && m_obj_col <= 9'd319 && m_obj_row <= 8'd239)
        else $error("complete frame out of range");

    // No-class frames carry zero fields
    a_no_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_COMPLETE && m_obj_class == -4'sd1 |->
            m_score == '0 && m_obj_col == '0 && m_obj_row == '0)
        else $error("no-class frame with nonzero fields");

endmodule

bind detection_frame_parser_core dfp_checker u_dfp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_obj_class (m_obj_class),
    .m_score     (m_score),
    .m_obj_col   (m_obj_col),
    .m_obj_row   (m_obj_row)
);
